### sv/ext2_bmw_pkg.sv
// Package with shared types and constants of the block map walker.
package ext2_bmw_pkg;

   localparam int STORE_BLOCKS_DEF  = 16;
   localparam int MAX_PTRS_LOG2_DEF = 10;
   localparam int DIRECT_COUNT      = 12;
   localparam int SLOT_COUNT        = 15;

   typedef enum logic [1:0] {
      CMD_SET_SLOT  = 2'd0,
      CMD_STORE_WR  = 2'd1,
      CMD_LOOKUP    = 2'd2,
      CMD_UNUSED    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_REACH      = 3'd1,
      ST_TABLE_VOL  = 3'd2,
      ST_PTR_VOL    = 3'd3,
      ST_NOT_STORED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_PTRS_LOG2     = 2'd0,
      CSR_VOLUME_BLOCKS = 2'd1,
      CSR_STORE_BASE    = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_STEP,
      BK_WAIT,
      BK_OUT
   } back_state_type;

   // A classified lookup as handed from the front to the back.
   typedef struct packed {
      logic [31:0] root;
      logic [35:0] rem;
      logic [1:0]  level;
      logic        done;
      status_type  status;
      logic [31:0] phys;
   } job_type;

endpackage

### sv/ext2_block_map_walker.sv
// A direct or out-of-reach lookup goes from the queue straight to the result; each table level walked
// adds a registered store read. The back walks one lookup at a time and takes the next only after
// the last result is taken; a store write word waits until queued and running lookups are walked.
// The front accepts further lookups while fewer than two lookups wait in the queue.
// Reset (synchronous, active high) clears control state and sets the registers to
// pointers-per-block log2 8, volume 65536 blocks, store base 0; stores are not cleared.
module ext2_block_map_walker #(
   parameter int STORE_BLOCKS  = ext2_bmw_pkg::STORE_BLOCKS_DEF,
   parameter int MAX_PTRS_LOG2 = ext2_bmw_pkg::MAX_PTRS_LOG2_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], slot[5:2], store_addr[19:6], word_value[51:20], file_index[99:52]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // phys_block[31:0], status[34:32], depth[36:35]
   output logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [3:0]  ptrs_log2_ff;
   logic [31:0] volume_blocks_ff, store_base_ff;
   logic [3:0]  lg;
   logic [1:0]  cmd;
   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   logic        walking, store_hold;
   ext2_bmw_pkg::job_type fq_job, qb_job;
   logic [31:0] phys;
   logic [2:0]  status;
   logic [1:0]  depth;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptrs_log2_ff     <= 4'd8;
         volume_blocks_ff <= 32'd65536;
         store_base_ff    <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            ext2_bmw_pkg::CSR_PTRS_LOG2:     ptrs_log2_ff <= csr_wdata[3:0];
            ext2_bmw_pkg::CSR_VOLUME_BLOCKS: volume_blocks_ff <= csr_wdata;
            ext2_bmw_pkg::CSR_STORE_BASE:    store_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lg = (ptrs_log2_ff < 4'd8) ? 4'd8 :
               (ptrs_log2_ff > 4'(MAX_PTRS_LOG2)) ? 4'(MAX_PTRS_LOG2) : ptrs_log2_ff;
   assign cmd = req_tdata[1:0];
   assign store_hold = qb_valid || walking;

   ext2_bmw_front #(.MAX_PTRS_LOG2(MAX_PTRS_LOG2)) u_front (
      .clock,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .cmd, .slot(req_tdata[5:2]), .word_value(req_tdata[51:20]),
      .file_index(req_tdata[99:52]), .lg, .store_hold,
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   ext2_bmw_queue u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
   );

   ext2_bmw_back #(.STORE_BLOCKS(STORE_BLOCKS), .MAX_PTRS_LOG2(MAX_PTRS_LOG2)) u_back (
      .clock, .reset,
      .st_we(req_tvalid && req_tready && cmd == ext2_bmw_pkg::CMD_STORE_WR),
      .st_addr(req_tdata[19:6]), .st_data(req_tdata[51:20]),
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .lg, .volume_blocks(volume_blocks_ff), .store_base(store_base_ff),
      .walking,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_phys(phys), .out_status(status), .out_depth(depth)
   );

   assign rsp_tdata = {3'd0, depth, status, phys};

endmodule

### sv/ext2_bmw_front.sv
// Front part: decodes words, holds inode pointers and classifies lookups.
module ext2_bmw_front #(
   parameter int MAX_PTRS_LOG2 = ext2_bmw_pkg::MAX_PTRS_LOG2_DEF
) (
   input  logic                         clock,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [1:0]                   cmd,
   input  logic [3:0]                   slot,
   input  logic [31:0]                  word_value,
   input  logic [47:0]                  file_index,
   input  logic [3:0]                   lg,
   input  logic                         store_hold,
   output logic                         job_valid,
   input  logic                         job_ready,
   output ext2_bmw_pkg::job_type        job
);

   logic [31:0] inode_ff [ext2_bmw_pkg::SLOT_COUNT];
   logic [47:0] r1, r2, r3, p1, p2, p3;
   ext2_bmw_pkg::job_type j;
   logic [1:0] lev;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready && cmd == ext2_bmw_pkg::CMD_SET_SLOT &&
          slot < 4'(ext2_bmw_pkg::SLOT_COUNT)) begin
         inode_ff[slot] <= word_value;
      end
   end

   // A store write waits until every queued or running walk has read its tables.
   assign in_ready  = (cmd == ext2_bmw_pkg::CMD_LOOKUP)   ? job_ready :
                      (cmd == ext2_bmw_pkg::CMD_STORE_WR) ? !store_hold : 1'b1;
   assign job_valid = in_valid && cmd == ext2_bmw_pkg::CMD_LOOKUP;

   always_comb begin
      p1 = 48'd1 << lg;
      p2 = 48'd1 << (5'(lg) + 5'(lg));
      p3 = 48'd1 << (6'(lg) * 6'd3);
      r1 = file_index - 48'(ext2_bmw_pkg::DIRECT_COUNT);
      r2 = r1 - p1;
      r3 = r2 - p2;
      j = '0;
      j.status = ext2_bmw_pkg::ST_OK;
      lev = 2'd0;
      if (file_index < 48'(ext2_bmw_pkg::DIRECT_COUNT)) begin
         j.done = 1'b1;
         j.phys = inode_ff[4'(file_index)];
      end else if (r1 < p1) begin
         lev = 2'd1;
         j.rem = 36'(r1);
      end else if (r2 < p2) begin
         lev = 2'd2;
         j.rem = 36'(r2);
      end else if (r3 < p3) begin
         lev = 2'd3;
         j.rem = 36'(r3);
      end else begin
         j.done = 1'b1;
         j.status = ext2_bmw_pkg::ST_REACH;
      end
      j.level = lev;
      j.root = (lev == 2'd0) ? 32'd0 :
               inode_ff[4'(ext2_bmw_pkg::DIRECT_COUNT) + 4'(lev) - 4'd1];
      job = j;
   end

endmodule

### sv/ext2_bmw_queue.sv
// Two-entry queue between the front and the back.
module ext2_bmw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  ext2_bmw_pkg::job_type wr_data,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output ext2_bmw_pkg::job_type rd_data
);

   ext2_bmw_pkg::job_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wp_ff ^ wr;
      rp_in  = rp_ff ^ rd;
      cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

### sv/ext2_bmw_back.sv
// Back part: walks pointer tables in the local store and delivers results.
module ext2_bmw_back #(
   parameter int STORE_BLOCKS  = ext2_bmw_pkg::STORE_BLOCKS_DEF,
   parameter int MAX_PTRS_LOG2 = ext2_bmw_pkg::MAX_PTRS_LOG2_DEF,
   localparam int LB_W = $clog2(STORE_BLOCKS),
   localparam int AW   = LB_W + MAX_PTRS_LOG2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  st_we,
   input  logic [13:0]           st_addr,
   input  logic [31:0]           st_data,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  ext2_bmw_pkg::job_type job,
   input  logic [3:0]            lg,
   input  logic [31:0]           volume_blocks,
   input  logic [31:0]           store_base,
   output logic                  walking,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           out_phys,
   output logic [2:0]            out_status,
   output logic [1:0]            out_depth
);

   localparam int WORDS = STORE_BLOCKS << MAX_PTRS_LOG2;

   logic [31:0] mem [WORDS];
   logic [31:0] rdata_ff;

   ext2_bmw_pkg::back_state_type state_ff, state_in;
   logic [31:0] cur_ff, cur_in;
   logic [35:0] rem_ff, rem_in;
   logic [1:0]  k_ff, k_in, lvl_ff, lvl_in;
   ext2_bmw_pkg::status_type st_ff, st_in;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0] local_blk;
   logic [5:0]  sh;
   logic [35:0] ent_wide;
   logic [MAX_PTRS_LOG2-1:0] entry;

   always_ff @(posedge clock) begin
      if (st_we && 32'(st_addr) < 32'(WORDS)) begin
         mem[AW'(st_addr)] <= st_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      local_blk = cur_ff - store_base;
      sh        = 6'(lg) * 6'(k_ff - 2'd1);
      ent_wide  = (rem_ff >> sh) & ((36'd1 << lg) - 36'd1);
      entry     = MAX_PTRS_LOG2'(ent_wide);
      rd_addr   = {LB_W'(local_blk), entry};
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      lvl_in    = lvl_ff;
      st_in     = st_ff;
      rd_en     = 1'b0;
      job_ready = 1'b0;
      unique case (state_ff)
         ext2_bmw_pkg::BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               cur_in = job.done ? job.phys : job.root;
               rem_in = job.rem;
               k_in   = job.level;
               lvl_in = job.level;
               st_in  = job.status;
               state_in = job.done ? ext2_bmw_pkg::BK_OUT : ext2_bmw_pkg::BK_STEP;
            end
         end
         ext2_bmw_pkg::BK_STEP: begin
            priority if (cur_ff == 32'd0) begin
               state_in = ext2_bmw_pkg::BK_OUT;
            end else if (cur_ff >= volume_blocks) begin
               st_in = ext2_bmw_pkg::ST_TABLE_VOL;
               cur_in = 32'd0;
               state_in = ext2_bmw_pkg::BK_OUT;
            end else if (local_blk >= 32'(STORE_BLOCKS)) begin
               st_in = ext2_bmw_pkg::ST_NOT_STORED;
               cur_in = 32'd0;
               state_in = ext2_bmw_pkg::BK_OUT;
            end else begin
               rd_en = 1'b1;
               state_in = ext2_bmw_pkg::BK_WAIT;
            end
         end
         ext2_bmw_pkg::BK_WAIT: begin
            if (rdata_ff != 32'd0 && rdata_ff >= volume_blocks) begin
               st_in = ext2_bmw_pkg::ST_PTR_VOL;
               cur_in = 32'd0;
               state_in = ext2_bmw_pkg::BK_OUT;
            end else begin
               cur_in = rdata_ff;
               k_in = k_ff - 2'd1;
               state_in = (k_ff == 2'd1) ? ext2_bmw_pkg::BK_OUT : ext2_bmw_pkg::BK_STEP;
            end
         end
         ext2_bmw_pkg::BK_OUT: begin
            if (out_ready) begin
               state_in = ext2_bmw_pkg::BK_IDLE;
            end
         end
         default: state_in = ext2_bmw_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ext2_bmw_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      k_ff   <= k_in;
      lvl_ff <= lvl_in;
      st_ff  <= st_in;
   end

   assign walking    = state_ff == ext2_bmw_pkg::BK_STEP || state_ff == ext2_bmw_pkg::BK_WAIT;
   assign out_valid  = state_ff == ext2_bmw_pkg::BK_OUT;
   assign out_phys   = cur_ff;
   assign out_status = st_ff;
   assign out_depth  = lvl_ff;

endmodule
